// ----- hw/rtl/wwsc_pkg.sv -----
// ----------------------------------------------------------------------------
// Weighted window steering control package
// Field widths, register indexes, reset values and track codes shared by the
// steering controller.
// ----------------------------------------------------------------------------
package wwsc_pkg;

	localparam int SAMPLE_W   = 8;
	localparam int KP_W       = 8;
	localparam int CENTER_W   = 14;
	localparam int LIMIT_W    = 13;
	localparam int THRESH_W   = 8;
	localparam int DUTY_W     = 14;
	localparam int ERR_W      = 16;
	localparam int TRACK_W    = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 14;

	// Error division: 25600 * |R - L| over L + R.
	localparam int SUM_W = SAMPLE_W + 1;
	localparam int QUO_W = 15;
	localparam int NUM_W = 23;
	localparam logic [QUO_W-1:0] PCT_Q8 = 15'd25600;

	// Drive product kp * error and its value after the shift by eight.
	localparam int PROD_W  = KP_W + 1 + ERR_W;
	localparam int DRIVE_W = PROD_W - 8;
	// Signed width of center plus or minus a drive or limit.
	localparam int DSUM_W  = CENTER_W + 4;

	localparam logic [DUTY_W-1:0] DUTY_MAX = 14'd16383;

	localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN        = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_DUTY    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_LIMIT     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOSS_THRESHOLD = 2'd3;

	localparam logic [KP_W-1:0]     KP_GAIN_RST        = 8'd25;
	localparam logic [CENTER_W-1:0] CENTER_DUTY_RST    = 14'd7500;
	localparam logic [LIMIT_W-1:0]  DUTY_LIMIT_RST     = 13'd2200;
	localparam logic [THRESH_W-1:0] LOSS_THRESHOLD_RST = 8'd200;

	localparam logic [TRACK_W-1:0] TRACK_NORMAL     = 2'd0;
	localparam logic [TRACK_W-1:0] TRACK_LEFT_LOST  = 2'd1;
	localparam logic [TRACK_W-1:0] TRACK_RIGHT_LOST = 2'd2;

	typedef struct packed {
		logic [KP_W-1:0]     kp_gain;
		logic [CENTER_W-1:0] center_duty;
		logic [LIMIT_W-1:0]  duty_limit;
		logic [THRESH_W-1:0] loss_threshold;
	} cfg_t;

endpackage

// ----- hw/rtl/weighted_window_steer_control.sv -----
// Requests are handled one at a time: a new request is taken only once the last result has
// been loaded, after the tap-serial window sums and the bit-serial error divider; the divider
// is skipped when the two levels are zero.
// A result waiting in the output register does not hold off the next request.
// Reset clears the windows, the held error and the control state, and loads
// the register defaults.
// ----------------------------------------------------------------------------
// Weighted window steering control
// Weighted moving average of left and right inductor samples, differential
// ratio error and proportional servo duty with lost-track hard turns.
// ----------------------------------------------------------------------------
module weighted_window_steer_control #(
	parameter int TAPS = 11
) (
	input  logic                                   clk,
	input  logic                                   arst_n,

	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [wwsc_pkg::SAMPLE_W-1:0]          left_sample,
	input  logic [wwsc_pkg::SAMPLE_W-1:0]          right_sample,

	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [wwsc_pkg::DUTY_W-1:0]            steer_duty,
	output logic [wwsc_pkg::SAMPLE_W-1:0]          left_level,
	output logic [wwsc_pkg::SAMPLE_W-1:0]          right_level,
	output logic signed [wwsc_pkg::ERR_W-1:0]      error_pct,
	output logic [wwsc_pkg::TRACK_W-1:0]           track_state,

	input  logic                                   cfg_wr_en,
	input  logic [wwsc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [wwsc_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam int SAMPLE_W = wwsc_pkg::SAMPLE_W;
	localparam int W_W      = $clog2(2 * TAPS);
	localparam int ACC_W    = $clog2(((1 << SAMPLE_W) - 1) * TAPS * TAPS + 1);
	localparam int AVG_DIV  = TAPS * TAPS;
	localparam int AVG_TOP  = AVG_DIV * (1 << (SAMPLE_W - 1));
	localparam int CNT_W    = ($clog2(TAPS) > 4) ? $clog2(TAPS) : 4;
	localparam int NUM_W    = wwsc_pkg::NUM_W;
	localparam int QUO_W    = wwsc_pkg::QUO_W;
	localparam int DRIVE_W  = wwsc_pkg::DRIVE_W;
	localparam int DSUM_W   = wwsc_pkg::DSUM_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ACC  = 3'd1;
	localparam logic [2:0] S_AVG  = 3'd2;
	localparam logic [2:0] S_PREP = 3'd3;
	localparam logic [2:0] S_ERR  = 3'd4;
	localparam logic [2:0] S_MUL  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	wwsc_pkg::cfg_t   cfg_q;

	logic [SAMPLE_W-1:0] win_l_q [TAPS];
	logic [SAMPLE_W-1:0] win_r_q [TAPS];
	logic signed [wwsc_pkg::ERR_W-1:0] held_q;

	logic [ACC_W-1:0]    acc_l_q, acc_r_q, dv_q;
	logic [W_W-1:0]      w_q;
	logic [SAMPLE_W-1:0] lv_q, rv_q;
	logic [NUM_W-1:0]    rem_q, dd_q;
	logic [QUO_W-1:0]    quo_q;
	logic                neg_q;
	logic signed [wwsc_pkg::PROD_W-1:0] prod_q;

	logic                              out_valid_q;
	logic [wwsc_pkg::DUTY_W-1:0]       duty_q;
	logic [SAMPLE_W-1:0]               lvl_l_q, lvl_r_q;
	logic signed [wwsc_pkg::ERR_W-1:0] err_q;
	logic [wwsc_pkg::TRACK_W-1:0]      track_q;

	logic [SAMPLE_W+W_W-1:0]           tap_l, tap_r;
	logic [ACC_W-1:0]                  acc_l_nx, acc_r_nx;
	logic                              ge_l, ge_r, ge_e;
	logic [wwsc_pkg::SUM_W-1:0]        lvl_sum;
	logic                              lvl_neg;
	logic [SAMPLE_W-1:0]               diff_mag;
	logic [NUM_W-1:0]                  num_mag;
	logic [QUO_W-1:0]                  quo_nx;
	logic [wwsc_pkg::ERR_W-1:0]        quo_ext;
	logic signed [wwsc_pkg::ERR_W-1:0] err_new;
	logic signed [DRIVE_W-1:0]         drive_raw, lim_s, drive;
	logic signed [DSUM_W-1:0]          center_s, duty_raw;
	logic [wwsc_pkg::DUTY_W-1:0]       duty_sat;
	logic [wwsc_pkg::TRACK_W-1:0]      track_nx;
	logic                              left_lost, right_lost;
	logic                              load;

	// Window taps are read at the head while the windows rotate once around.
	assign tap_l    = (SAMPLE_W + W_W)'(win_l_q[0]) * (SAMPLE_W + W_W)'(w_q);
	assign tap_r    = (SAMPLE_W + W_W)'(win_r_q[0]) * (SAMPLE_W + W_W)'(w_q);
	assign acc_l_nx = acc_l_q + ACC_W'(tap_l);
	assign acc_r_nx = acc_r_q + ACC_W'(tap_r);

	assign ge_l = (acc_l_q >= dv_q);
	assign ge_r = (acc_r_q >= dv_q);

	assign lvl_sum  = {1'b0, lv_q} + {1'b0, rv_q};
	assign lvl_neg  = (rv_q < lv_q);
	assign diff_mag = lvl_neg ? (lv_q - rv_q) : (rv_q - lv_q);
	assign num_mag  = NUM_W'(wwsc_pkg::PCT_Q8) * NUM_W'(diff_mag);

	assign ge_e    = (rem_q >= dd_q);
	assign quo_nx  = {quo_q[QUO_W-2:0], ge_e};
	assign quo_ext = {1'b0, quo_nx};
	assign err_new = neg_q ? -$signed(quo_ext) : $signed(quo_ext);

	// The arithmetic shift by eight rounds toward minus infinity.
	assign drive_raw = $signed(prod_q[wwsc_pkg::PROD_W-1:8]);
	assign lim_s     = $signed({(DRIVE_W - wwsc_pkg::LIMIT_W)'(0), cfg_q.duty_limit});
	always_comb begin
		if (drive_raw > lim_s) begin
			drive = lim_s;
		end else if (drive_raw < -lim_s) begin
			drive = -lim_s;
		end else begin
			drive = drive_raw;
		end
	end

	assign center_s   = $signed({(DSUM_W - wwsc_pkg::CENTER_W)'(0), cfg_q.center_duty});
	assign left_lost  = (lv_q < cfg_q.loss_threshold);
	assign right_lost = (rv_q < cfg_q.loss_threshold);

	always_comb begin
		if (left_lost && !right_lost) begin
			duty_raw = center_s + DSUM_W'(lim_s);
			track_nx = wwsc_pkg::TRACK_LEFT_LOST;
		end else if (right_lost && !left_lost) begin
			duty_raw = center_s - DSUM_W'(lim_s);
			track_nx = wwsc_pkg::TRACK_RIGHT_LOST;
		end else begin
			duty_raw = center_s + DSUM_W'(drive);
			track_nx = wwsc_pkg::TRACK_NORMAL;
		end
		if (duty_raw < 0) begin
			duty_sat = '0;
		end else if (duty_raw > $signed(DSUM_W'(wwsc_pkg::DUTY_MAX))) begin
			duty_sat = wwsc_pkg::DUTY_MAX;
		end else begin
			duty_sat = duty_raw[wwsc_pkg::DUTY_W-1:0];
		end
	end

	assign load     = (state_q == S_OUT) && (!out_valid_q || !out_stall);
	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp_gain        <= wwsc_pkg::KP_GAIN_RST;
			cfg_q.center_duty    <= wwsc_pkg::CENTER_DUTY_RST;
			cfg_q.duty_limit     <= wwsc_pkg::DUTY_LIMIT_RST;
			cfg_q.loss_threshold <= wwsc_pkg::LOSS_THRESHOLD_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				wwsc_pkg::REG_KP_GAIN: begin
					cfg_q.kp_gain <= cfg_data[wwsc_pkg::KP_W-1:0];
				end
				wwsc_pkg::REG_CENTER_DUTY: begin
					cfg_q.center_duty <= cfg_data[wwsc_pkg::CENTER_W-1:0];
				end
				wwsc_pkg::REG_DUTY_LIMIT: begin
					cfg_q.duty_limit <= cfg_data[wwsc_pkg::LIMIT_W-1:0];
				end
				wwsc_pkg::REG_LOSS_THRESHOLD: begin
					cfg_q.loss_threshold <= cfg_data[wwsc_pkg::THRESH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			held_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < TAPS; i++) begin
				win_l_q[i] <= '0;
				win_r_q[i] <= '0;
			end
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						for (int i = 0; i < TAPS - 1; i++) begin
							win_l_q[i] <= win_l_q[i+1];
							win_r_q[i] <= win_r_q[i+1];
						end
						win_l_q[TAPS-1] <= left_sample;
						win_r_q[TAPS-1] <= right_sample;
						cnt_q   <= CNT_W'(TAPS - 1);
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					// One full rotation leaves the windows in their original order.
					for (int i = 0; i < TAPS - 1; i++) begin
						win_l_q[i] <= win_l_q[i+1];
						win_r_q[i] <= win_r_q[i+1];
					end
					win_l_q[TAPS-1] <= win_l_q[0];
					win_r_q[TAPS-1] <= win_r_q[0];
					if (cnt_q == '0) begin
						cnt_q   <= CNT_W'(SAMPLE_W - 1);
						state_q <= S_AVG;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_AVG: begin
					if (cnt_q == '0) begin
						state_q <= S_PREP;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_PREP: begin
					// With both levels at zero the previous error stands.
					if (lvl_sum == '0) begin
						state_q <= S_MUL;
					end else begin
						cnt_q   <= CNT_W'(QUO_W - 1);
						state_q <= S_ERR;
					end
				end
				S_ERR: begin
					if (cnt_q == '0) begin
						held_q  <= err_new;
						state_q <= S_MUL;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_MUL: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				acc_l_q <= '0;
				acc_r_q <= '0;
				w_q     <= W_W'(1);
			end
			S_ACC: begin
				acc_l_q <= acc_l_nx;
				acc_r_q <= acc_r_nx;
				w_q     <= w_q + W_W'(2);
				dv_q    <= ACC_W'(AVG_TOP);
			end
			S_AVG: begin
				// Restoring division by TAPS squared, one quotient bit a cycle.
				if (ge_l) begin
					acc_l_q <= acc_l_q - dv_q;
				end
				if (ge_r) begin
					acc_r_q <= acc_r_q - dv_q;
				end
				lv_q <= {lv_q[SAMPLE_W-2:0], ge_l};
				rv_q <= {rv_q[SAMPLE_W-2:0], ge_r};
				dv_q <= dv_q >> 1;
			end
			S_PREP: begin
				rem_q <= num_mag;
				dd_q  <= NUM_W'(lvl_sum) << (QUO_W - 1);
				neg_q <= lvl_neg;
			end
			S_ERR: begin
				if (ge_e) begin
					rem_q <= rem_q - dd_q;
				end
				quo_q <= quo_nx;
				dd_q  <= dd_q >> 1;
			end
			S_MUL: begin
				prod_q <= wwsc_pkg::PROD_W'($signed({1'b0, cfg_q.kp_gain}) * held_q);
			end
			S_OUT: begin
				if (load) begin
					duty_q  <= duty_sat;
					lvl_l_q <= lv_q;
					lvl_r_q <= rv_q;
					err_q   <= held_q;
					track_q <= track_nx;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign steer_duty  = duty_q;
	assign left_level  = lvl_l_q;
	assign right_level = lvl_r_q;
	assign error_pct   = err_q;
	assign track_state = track_q;

endmodule

// ----- test/weighted_window_steer_control_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted window steering control testbench
// Drives sample pairs through the steering controller under random input and
// output stalls and checks every result against a cycle-free predictor of the
// window averages, the differential error and the duty. Register settings are
// changed between phases while the block is idle, covering their extremes.
// ----------------------------------------------------------------------------
module weighted_window_steer_control_test;

	localparam int TAPS = 11;

	typedef struct packed {
		logic [wwsc_pkg::DUTY_W-1:0]   duty;
		logic [wwsc_pkg::SAMPLE_W-1:0] left_level;
		logic [wwsc_pkg::SAMPLE_W-1:0] right_level;
		logic [wwsc_pkg::ERR_W-1:0]    error;
		logic [wwsc_pkg::TRACK_W-1:0]  track;
	} steer_result_t;

	typedef enum int {
		STYLE_TRACK,
		STYLE_FAINT,
		STYLE_NOISE
	} sample_style_t;

	// Predicts one result per request and keeps the results still owed.
	class steer_scoreboard;
		logic [wwsc_pkg::SAMPLE_W-1:0] left_win [TAPS];
		logic [wwsc_pkg::SAMPLE_W-1:0] right_win [TAPS];
		int                            held_err;
		logic [wwsc_pkg::KP_W-1:0]     kp;
		logic [wwsc_pkg::CENTER_W-1:0] center;
		logic [wwsc_pkg::LIMIT_W-1:0]  limit;
		logic [wwsc_pkg::THRESH_W-1:0] thresh;
		steer_result_t                 pending [$];
		int                            fail_count;
		int                            result_count;

		function new();
			int i;
			for (i = 0; i < TAPS; i++) begin
				left_win[i] = '0;
				right_win[i] = '0;
			end
			held_err = 0;
			kp = wwsc_pkg::KP_GAIN_RST;
			center = wwsc_pkg::CENTER_DUTY_RST;
			limit = wwsc_pkg::DUTY_LIMIT_RST;
			thresh = wwsc_pkg::LOSS_THRESHOLD_RST;
			fail_count = 0;
			result_count = 0;
		endfunction

		function void set_register(logic [wwsc_pkg::CFG_IDX_W-1:0] idx,
			logic [wwsc_pkg::CFG_DATA_W-1:0] value);
			case (idx)
				wwsc_pkg::REG_KP_GAIN:        kp = value[wwsc_pkg::KP_W-1:0];
				wwsc_pkg::REG_CENTER_DUTY:    center = value[wwsc_pkg::CENTER_W-1:0];
				wwsc_pkg::REG_DUTY_LIMIT:     limit = value[wwsc_pkg::LIMIT_W-1:0];
				wwsc_pkg::REG_LOSS_THRESHOLD: thresh = value[wwsc_pkg::THRESH_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned weighted_level(logic [wwsc_pkg::SAMPLE_W-1:0] win [TAPS]);
			int unsigned acc;
			int i;
			acc = 0;
			for (i = 0; i < TAPS; i++)
				acc += win[i] * (2 * i + 1);
			return acc / (TAPS * TAPS);
		endfunction

		function void note_request(logic [wwsc_pkg::SAMPLE_W-1:0] l,
			logic [wwsc_pkg::SAMPLE_W-1:0] r);
			int unsigned lv, rv;
			int drive, lim, duty, i;
			steer_result_t exp_res;
			for (i = 0; i < TAPS - 1; i++) begin
				left_win[i] = left_win[i + 1];
				right_win[i] = right_win[i + 1];
			end
			left_win[TAPS - 1] = l;
			right_win[TAPS - 1] = r;
			lv = weighted_level(left_win);
			rv = weighted_level(right_win);
			// A zero level sum leaves the last error in place.
			if (lv + rv != 0)
				held_err = (25600 * (int'(rv) - int'(lv))) / int'(lv + rv);
			lim = int'(limit);
			drive = (int'(kp) * held_err) >>> 8;
			if (drive > lim)
				drive = lim;
			if (drive < -lim)
				drive = -lim;
			if (lv < thresh && rv >= thresh) begin
				duty = int'(center) + lim;
				exp_res.track = wwsc_pkg::TRACK_LEFT_LOST;
			end else if (rv < thresh && lv >= thresh) begin
				duty = int'(center) - lim;
				exp_res.track = wwsc_pkg::TRACK_RIGHT_LOST;
			end else begin
				duty = int'(center) + drive;
				exp_res.track = wwsc_pkg::TRACK_NORMAL;
			end
			if (duty < 0)
				duty = 0;
			if (duty > int'(wwsc_pkg::DUTY_MAX))
				duty = int'(wwsc_pkg::DUTY_MAX);
			exp_res.duty = duty[wwsc_pkg::DUTY_W-1:0];
			exp_res.left_level = lv[wwsc_pkg::SAMPLE_W-1:0];
			exp_res.right_level = rv[wwsc_pkg::SAMPLE_W-1:0];
			exp_res.error = held_err[wwsc_pkg::ERR_W-1:0];
			pending.push_back(exp_res);
		endfunction

		function void check_result(steer_result_t got);
			steer_result_t want;
			result_count++;
			if (pending.size() == 0) begin
				$error("result arrived with no request outstanding");
				fail_count++;
				return;
			end
			want = pending.pop_front();
			if (got.duty !== want.duty) begin
				$error("steer_duty: expected %0d, got %0d", want.duty, got.duty);
				fail_count++;
			end
			if (got.left_level !== want.left_level) begin
				$error("left_level: expected %0d, got %0d", want.left_level, got.left_level);
				fail_count++;
			end
			if (got.right_level !== want.right_level) begin
				$error("right_level: expected %0d, got %0d", want.right_level,
					got.right_level);
				fail_count++;
			end
			if (got.error !== want.error) begin
				$error("error_pct: expected %0d, got %0d", $signed(want.error),
					$signed(got.error));
				fail_count++;
			end
			if (got.track !== want.track) begin
				$error("track_state: expected %0d, got %0d", want.track, got.track);
				fail_count++;
			end
		endfunction
	endclass

	logic                                 clk;
	logic                                 arst_n;
	logic                                 in_valid;
	logic                                 in_stall;
	logic [wwsc_pkg::SAMPLE_W-1:0]        left_sample;
	logic [wwsc_pkg::SAMPLE_W-1:0]        right_sample;
	logic                                 out_valid;
	logic                                 out_stall;
	logic [wwsc_pkg::DUTY_W-1:0]          steer_duty;
	logic [wwsc_pkg::SAMPLE_W-1:0]        left_level;
	logic [wwsc_pkg::SAMPLE_W-1:0]        right_level;
	logic signed [wwsc_pkg::ERR_W-1:0]    error_pct;
	logic [wwsc_pkg::TRACK_W-1:0]         track_state;
	logic                                 cfg_wr_en;
	logic [wwsc_pkg::CFG_IDX_W-1:0]       cfg_index;
	logic [wwsc_pkg::CFG_DATA_W-1:0]      cfg_data;

	steer_scoreboard sb;
	bit              quiet = 1'b0;

	weighted_window_steer_control #(
		.TAPS(TAPS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.steer_duty   (steer_duty),
		.left_level   (left_level),
		.right_level  (right_level),
		.error_pct    (error_pct),
		.track_state  (track_state),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Offers one request, with an occasional idle burst in front of it.
	task automatic send_sample(input logic [wwsc_pkg::SAMPLE_W-1:0] l,
		input logic [wwsc_pkg::SAMPLE_W-1:0] r);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		left_sample <= l;
		right_sample <= r;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_request(l, r);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending.size() != 0);
	endtask

	// Leaves the write enable high; the caller lowers it after the last write.
	task automatic write_register(input logic [wwsc_pkg::CFG_IDX_W-1:0] idx,
		input logic [wwsc_pkg::CFG_DATA_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		sb.set_register(idx, value);
	endtask

	task automatic apply_settings(input logic [wwsc_pkg::CFG_DATA_W-1:0] kp_word,
		input logic [wwsc_pkg::CFG_DATA_W-1:0] center_word,
		input logic [wwsc_pkg::CFG_DATA_W-1:0] limit_word,
		input logic [wwsc_pkg::CFG_DATA_W-1:0] thresh_word);
		wait_drain();
		write_register(wwsc_pkg::REG_KP_GAIN, kp_word);
		write_register(wwsc_pkg::REG_CENTER_DUTY, center_word);
		write_register(wwsc_pkg::REG_DUTY_LIMIT, limit_word);
		write_register(wwsc_pkg::REG_LOSS_THRESHOLD, thresh_word);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic int pick_base(sample_style_t style);
		if (style == STYLE_FAINT)
			return ($urandom_range(0, 3) != 0) ? 0 : int'($urandom_range(0, 255));
		case ($urandom_range(0, 3))
			0:       return $urandom_range(0, 60);
			1:       return $urandom_range(100, 220);
			default: return $urandom_range(190, 255);
		endcase
	endfunction

	function automatic logic [wwsc_pkg::SAMPLE_W-1:0] next_sample(int base, int spread);
		int s;
		s = base + int'($urandom_range(0, 2 * spread)) - spread;
		if (s < 0)
			s = 0;
		if (s > 255)
			s = 255;
		return s[wwsc_pkg::SAMPLE_W-1:0];
	endfunction

	// Mostly slowly moving levels with noise, so that both lost cases, steady
	// tracking and all-zero windows are reached.
	task automatic run_random(input int count, input sample_style_t style);
		int i, l_base, r_base, spread;
		l_base = 128;
		r_base = 128;
		spread = (style == STYLE_FAINT) ? 0 : 12;
		for (i = 0; i < count; i++) begin
			if ($urandom_range(0, 11) == 0) begin
				l_base = pick_base(style);
				r_base = pick_base(style);
			end
			if ($urandom_range(0, 199) == 0)
				wait_drain();
			if (style == STYLE_NOISE || $urandom_range(0, 19) == 0)
				send_sample(wwsc_pkg::SAMPLE_W'($urandom_range(0, 255)),
					wwsc_pkg::SAMPLE_W'($urandom_range(0, 255)));
			else
				send_sample(next_sample(l_base, spread), next_sample(r_base, spread));
		end
	endtask

	task automatic run_directed();
		send_sample(8'd0, 8'd0);
		send_sample(8'd255, 8'd0);
		send_sample(8'd0, 8'd255);
		send_sample(8'hAA, 8'h55);
		send_sample(8'h55, 8'hAA);
		repeat (8) send_sample(8'd255, 8'd255);
		// Left side drops out while the right stays strong, then the reverse.
		repeat (6) send_sample(8'd0, 8'd255);
		repeat (6) send_sample(8'd255, 8'd0);
	endtask

	initial begin : result_sink
		int hold;
		bit long_hold_done;
		steer_result_t got;
		hold = 0;
		long_hold_done = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got.duty = steer_duty;
				got.left_level = left_level;
				got.right_level = right_level;
				got.error = error_pct;
				got.track = track_state;
				sb.check_result(got);
			end
			// One long hold-off lets the block fill up and stall its requests.
			if (hold > 0)
				hold--;
			else if (!long_hold_done && sb.result_count >= 60) begin
				hold = 400;
				long_hold_done = 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0)
				hold = $urandom_range(1, 6);
			out_stall <= (hold > 0);
		end
	end

	initial begin
		int phase;
		sample_style_t style;
		sb = new();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		left_sample <= '0;
		right_sample <= '0;
		cfg_wr_en <= 1'b0;
		cfg_index <= wwsc_pkg::REG_KP_GAIN;
		cfg_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		// Upper bits beyond each register's width are set on purpose; they are
		// dropped on the write.
		for (phase = 0; phase < 10; phase++) begin
			case (phase)
				0: apply_settings(14'h3FFF, 14'h0000, 14'h3FFF, 14'h3F00);
				1: apply_settings(14'h3F00, 14'h3FFF, 14'h2000, 14'h00FF);
				2: apply_settings(14'h00FF, 14'h3FFF, 14'h1FFF, 14'h0080);
				3: apply_settings(wwsc_pkg::CFG_DATA_W'(wwsc_pkg::KP_GAIN_RST),
					wwsc_pkg::CFG_DATA_W'(wwsc_pkg::CENTER_DUTY_RST),
					wwsc_pkg::CFG_DATA_W'(wwsc_pkg::DUTY_LIMIT_RST),
					wwsc_pkg::CFG_DATA_W'(wwsc_pkg::LOSS_THRESHOLD_RST));
				default: apply_settings(wwsc_pkg::CFG_DATA_W'($urandom_range(0, 16383)),
					wwsc_pkg::CFG_DATA_W'($urandom_range(0, 16383)),
					wwsc_pkg::CFG_DATA_W'($urandom_range(0, 16383)),
					wwsc_pkg::CFG_DATA_W'($urandom_range(0, 16383)));
			endcase
			if (phase == 9)
				quiet = 1'b1;
			case (phase % 4)
				2:       style = STYLE_FAINT;
				3:       style = STYLE_NOISE;
				default: style = STYLE_TRACK;
			endcase
			run_random(150, style);
		end

		wait_drain();
		repeat (TAPS + 30) @(posedge clk);
		if (sb.fail_count == 0 && sb.pending.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- weighted_window_steer_control.f -----
hw/rtl/wwsc_pkg.sv
hw/rtl/weighted_window_steer_control.sv
test/weighted_window_steer_control_test.sv
